@@ design/hsv_led_color_render_assert.svh @@
// Assertion macros shared by the lamp color render RTL.
// Needs clk and rst_n in the scope of the including module.
`ifndef HSV_LED_COLOR_RENDER_ASSERT_SVH
`define HSV_LED_COLOR_RENDER_ASSERT_SVH

// Checked only outside reset.
`define HLCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HLCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/hlcr_pkg.sv @@
// Types and constants for the lamp color render pipeline.
// No dependencies.
package hlcr_pkg;

  localparam logic [7:0]  FULL_SCALE = 8'd254;
  localparam logic [7:0]  DRIVE_MAX  = 8'd255;
  localparam logic [8:0]  HUE_TURN   = 9'd360;
  localparam logic [8:0]  SECTOR_DEG = 9'd60;

  // floor(x/360) == (x*RECIP_360) >> 26 for x < 2^17
  localparam logic [17:0] RECIP_360       = 18'd186414;
  localparam int          RECIP_360_SHIFT = 26;
  // floor(x/254) == (x*RECIP_254) >> 24 for x < 2^16
  localparam logic [16:0] RECIP_254       = 17'd66053;
  localparam int          RECIP_254_SHIFT = 24;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic       rgb_on;
    logic [8:0] hue_deg;
    logic [7:0] sat;
    logic [7:0] bright;
    logic       white_enable;
    logic [7:0] white_bright;
  } hlcr_in_t;

  typedef struct packed {
    logic       rgb_on;
    sector_t    sector;
    logic [8:0] pos;
    logic [7:0] sat;
    logic [7:0] lvl;
    logic [7:0] white;
  } hlcr_sect_t;

  typedef struct packed {
    logic       rgb_on;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] lvl;
    logic [7:0] white;
  } hlcr_color_t;

  typedef struct packed {
    logic [7:0] white;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } hlcr_out_t;

endpackage

@@ design/hlcr_front.sv @@
// Front stages: hue wrap, level clamps, then sector and in-sector position.
// Depends on hlcr_pkg.
module hlcr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  hlcr_pkg::hlcr_in_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output hlcr_pkg::hlcr_sect_t dn_item
);
  import hlcr_pkg::*;

  typedef struct packed {
    logic       rgb_on;
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] lvl;
    logic [7:0] white;
  } norm_t;

  logic       va_r, vb_r;
  logic       rdy_a, rdy_b;
  norm_t      na_r, na_nxt;
  hlcr_sect_t sb_r, sb_nxt;
  logic [8:0] base;
  logic [5:0] off;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;
  assign dn_valid = vb_r;
  assign dn_item  = sb_r;

  always_comb begin
    na_nxt.rgb_on = up_item.rgb_on;
    na_nxt.hue    = (up_item.hue_deg >= HUE_TURN) ? (up_item.hue_deg - HUE_TURN)
                                                  : up_item.hue_deg;
    na_nxt.sat    = (up_item.sat > FULL_SCALE) ? FULL_SCALE : up_item.sat;
    na_nxt.lvl    = (up_item.bright > FULL_SCALE) ? FULL_SCALE : up_item.bright;
    na_nxt.white  = !up_item.white_enable ? 8'd0 :
                    (up_item.white_bright > FULL_SCALE) ? FULL_SCALE
                                                        : up_item.white_bright;
  end

  always_comb begin
    sb_nxt.rgb_on = na_r.rgb_on;
    sb_nxt.sat    = na_r.sat;
    sb_nxt.lvl    = na_r.lvl;
    sb_nxt.white  = na_r.white;
    priority if (na_r.hue < SECTOR_DEG) begin
      sb_nxt.sector = SEC_RED_YEL;
      base          = 9'd0;
    end else if (na_r.hue < 9'(2 * SECTOR_DEG)) begin
      sb_nxt.sector = SEC_YEL_GRN;
      base          = SECTOR_DEG;
    end else if (na_r.hue < 9'(3 * SECTOR_DEG)) begin
      sb_nxt.sector = SEC_GRN_CYN;
      base          = 9'(2 * SECTOR_DEG);
    end else if (na_r.hue < 9'(4 * SECTOR_DEG)) begin
      sb_nxt.sector = SEC_CYN_BLU;
      base          = 9'(3 * SECTOR_DEG);
    end else if (na_r.hue < 9'(5 * SECTOR_DEG)) begin
      sb_nxt.sector = SEC_BLU_MAG;
      base          = 9'(4 * SECTOR_DEG);
    end else begin
      sb_nxt.sector = SEC_MAG_RED;
      base          = 9'(5 * SECTOR_DEG);
    end
    off        = 6'(na_r.hue - base);
    // offset times six
    sb_nxt.pos = 9'({off, 2'b00}) + 9'({off, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) na_r <= na_nxt;
    if (rdy_b && va_r)     sb_r <= sb_nxt;
  end

endmodule

@@ design/hlcr_chroma.sv @@
// Chroma stages: saturation products, divide by 360, sector channel select.
// Depends on hlcr_pkg.
module hlcr_chroma (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  hlcr_pkg::hlcr_sect_t up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output hlcr_pkg::hlcr_color_t dn_item
);
  import hlcr_pkg::*;

  typedef struct packed {
    logic        rgb_on;
    sector_t     sector;
    logic [16:0] pa;
    logic [16:0] pb;
    logic [7:0]  sat;
    logic [7:0]  lvl;
    logic [7:0]  white;
  } prod_t;

  typedef struct packed {
    logic       rgb_on;
    sector_t    sector;
    logic [7:0] ta;
    logic [7:0] tb;
    logic [7:0] sat;
    logic [7:0] lvl;
    logic [7:0] white;
  } quot_t;

  logic        vc_r, vd_r, ve_r;
  logic        rdy_c, rdy_d, rdy_e;
  prod_t       pc_r, pc_nxt;
  quot_t       qd_r, qd_nxt;
  hlcr_color_t ce_r, ce_nxt;
  logic [8:0]  rem_pos;
  logic [34:0] mul_a, mul_b;
  logic [7:0]  lo, fall, rise;

  assign rdy_e    = !ve_r || dn_ready;
  assign rdy_d    = !vd_r || rdy_e;
  assign rdy_c    = !vc_r || rdy_d;
  assign up_ready = rdy_c;
  assign dn_valid = ve_r;
  assign dn_item  = ce_r;

  always_comb begin
    rem_pos       = HUE_TURN - up_item.pos;
    pc_nxt.rgb_on = up_item.rgb_on;
    pc_nxt.sector = up_item.sector;
    pc_nxt.pa     = {9'd0, up_item.sat} * {8'd0, up_item.pos};
    pc_nxt.pb     = {9'd0, up_item.sat} * {8'd0, rem_pos};
    pc_nxt.sat    = up_item.sat;
    pc_nxt.lvl    = up_item.lvl;
    pc_nxt.white  = up_item.white;
  end

  always_comb begin
    mul_a         = {18'd0, pc_r.pa} * {17'd0, RECIP_360};
    mul_b         = {18'd0, pc_r.pb} * {17'd0, RECIP_360};
    qd_nxt.rgb_on = pc_r.rgb_on;
    qd_nxt.sector = pc_r.sector;
    qd_nxt.ta     = mul_a[RECIP_360_SHIFT +: 8];
    qd_nxt.tb     = mul_b[RECIP_360_SHIFT +: 8];
    qd_nxt.sat    = pc_r.sat;
    qd_nxt.lvl    = pc_r.lvl;
    qd_nxt.white  = pc_r.white;
  end

  // 255*(254-t)/254 is 254-t, plus one when t is zero
  always_comb begin
    lo   = FULL_SCALE - qd_r.sat;
    fall = (qd_r.ta == 8'd0) ? DRIVE_MAX : (FULL_SCALE - qd_r.ta);
    rise = (qd_r.tb == 8'd0) ? DRIVE_MAX : (FULL_SCALE - qd_r.tb);
    ce_nxt.rgb_on = qd_r.rgb_on;
    ce_nxt.lvl    = qd_r.lvl;
    ce_nxt.white  = qd_r.white;
    if (qd_r.sat == 8'd0) begin
      ce_nxt.red   = DRIVE_MAX;
      ce_nxt.green = DRIVE_MAX;
      ce_nxt.blue  = DRIVE_MAX;
    end else begin
      unique case (qd_r.sector)
        SEC_RED_YEL: begin
          ce_nxt.red = DRIVE_MAX; ce_nxt.green = rise; ce_nxt.blue = lo;
        end
        SEC_YEL_GRN: begin
          ce_nxt.red = fall; ce_nxt.green = DRIVE_MAX; ce_nxt.blue = lo;
        end
        SEC_GRN_CYN: begin
          ce_nxt.red = lo; ce_nxt.green = DRIVE_MAX; ce_nxt.blue = rise;
        end
        SEC_CYN_BLU: begin
          ce_nxt.red = lo; ce_nxt.green = fall; ce_nxt.blue = DRIVE_MAX;
        end
        SEC_BLU_MAG: begin
          ce_nxt.red = rise; ce_nxt.green = lo; ce_nxt.blue = DRIVE_MAX;
        end
        default: begin
          ce_nxt.red = DRIVE_MAX; ce_nxt.green = lo; ce_nxt.blue = fall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (rdy_c) vc_r <= up_valid;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && up_valid) pc_r <= pc_nxt;
    if (rdy_d && vc_r)     qd_r <= qd_nxt;
    if (rdy_e && vd_r)     ce_r <= ce_nxt;
  end

endmodule

@@ design/hlcr_scale.sv @@
// Brightness stages: channel times level, then divide by 254 into the output register.
// Depends on hlcr_pkg.
module hlcr_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  hlcr_pkg::hlcr_color_t up_item,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output hlcr_pkg::hlcr_out_t   dn_item
);
  import hlcr_pkg::*;

  typedef struct packed {
    logic [15:0] pr;
    logic [15:0] pg;
    logic [15:0] pb;
    logic [7:0]  white;
  } lvl_prod_t;

  logic        vf_r, vg_r;
  logic        rdy_f, rdy_g;
  lvl_prod_t   lf_r, lf_nxt;
  hlcr_out_t   og_r, og_nxt;
  logic [32:0] qr, qg, qb;

  assign rdy_g    = !vg_r || dn_ready;
  assign rdy_f    = !vf_r || rdy_g;
  assign up_ready = rdy_f;
  assign dn_valid = vg_r;
  assign dn_item  = og_r;

  // drop color when the lamp is off
  always_comb begin
    lf_nxt.pr    = up_item.rgb_on ? ({8'd0, up_item.red}   * {8'd0, up_item.lvl}) : 16'd0;
    lf_nxt.pg    = up_item.rgb_on ? ({8'd0, up_item.green} * {8'd0, up_item.lvl}) : 16'd0;
    lf_nxt.pb    = up_item.rgb_on ? ({8'd0, up_item.blue}  * {8'd0, up_item.lvl}) : 16'd0;
    lf_nxt.white = up_item.white;
  end

  always_comb begin
    qr           = {17'd0, lf_r.pr} * {16'd0, RECIP_254};
    qg           = {17'd0, lf_r.pg} * {16'd0, RECIP_254};
    qb           = {17'd0, lf_r.pb} * {16'd0, RECIP_254};
    og_nxt.red   = qr[RECIP_254_SHIFT +: 8];
    og_nxt.green = qg[RECIP_254_SHIFT +: 8];
    og_nxt.blue  = qb[RECIP_254_SHIFT +: 8];
    og_nxt.white = lf_r.white;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else begin
      if (rdy_f) vf_r <= up_valid;
      if (rdy_g) vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && up_valid) lf_r <= lf_nxt;
    if (rdy_g && vf_r)     og_r <= og_nxt;
  end

endmodule

@@ design/hsv_led_color_render.sv @@
// Seven register stages, each with its own valid bit, in the front, chroma and scale
// sections; out_tvalid is the valid bit of the last stage.
// Throughput: one request per cycle while the output is not stalled.
// A stalled output holds its stage; upstream stages keep filling bubbles until full.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
// Top level of the lamp color render pipeline: front, chroma and scale sections.
// Depends on hlcr_pkg, hlcr_front, hlcr_chroma, hlcr_scale and the assertion macros.
`include "hsv_led_color_render_assert.svh"

module hsv_led_color_render (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // rgb_on[0], hue_deg[9:1], sat[17:10], bright[25:18], white_enable[26],
  // white_bright[34:27], zero pad [39:35]
  input  logic [hlcr_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // red[7:0], green[15:8], blue[23:16], white[31:24]
  output logic [hlcr_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import hlcr_pkg::*;

  hlcr_in_t    in_item;
  hlcr_sect_t  sect_item;
  hlcr_color_t color_item;
  hlcr_out_t   out_item;
  logic        sect_valid, sect_ready;
  logic        color_valid, color_ready;

  assign in_item.rgb_on       = in_tdata[0];
  assign in_item.hue_deg      = in_tdata[9:1];
  assign in_item.sat          = in_tdata[17:10];
  assign in_item.bright       = in_tdata[25:18];
  assign in_item.white_enable = in_tdata[26];
  assign in_item.white_bright = in_tdata[34:27];

  hlcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (in_item),
    .dn_valid (sect_valid),
    .dn_ready (sect_ready),
    .dn_item  (sect_item)
  );

  hlcr_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sect_valid),
    .up_ready (sect_ready),
    .up_item  (sect_item),
    .dn_valid (color_valid),
    .dn_ready (color_ready),
    .dn_item  (color_item)
  );

  hlcr_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (color_valid),
    .up_ready (color_ready),
    .up_item  (color_item),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_item  (out_item)
  );

  assign out_tdata = out_item;

  `HLCR_ASSERT(a_white_in_range, out_tvalid |-> (out_tdata[31:24] <= FULL_SCALE), "white above full scale")
  `HLCR_ASSERT(a_empty_accepts, !out_tvalid |-> in_tready, "input stalled with empty output stage")
  `HLCR_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

@@ tb/hsv_led_color_render_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for hsv_led_color_render: lamp settings in, RGBW drive values out.
// Depends on hlcr_pkg and the hsv_led_color_render RTL; uses no files or arguments.

module hsv_led_color_render_test;
  import hlcr_pkg::*;

  // Scoreboard: predicts the RGBW drive for each accepted setting and checks results in order.
  class rgbw_board;
    hlcr_out_t   pending_rgbw[$];
    int unsigned settings_seen;
    int unsigned drives_checked;
    int unsigned mismatches;

    function hlcr_out_t render_rgbw(hlcr_in_t s);
      hlcr_out_t   o;
      int unsigned hue, sv, lvl, wb, pos, lo, fall, rise, r, g, b;
      sector_t     sec;
      hue = s.hue_deg % HUE_TURN;
      sv  = (s.sat > FULL_SCALE) ? FULL_SCALE : s.sat;
      lvl = (s.bright > FULL_SCALE) ? FULL_SCALE : s.bright;
      wb  = (s.white_bright > FULL_SCALE) ? FULL_SCALE : s.white_bright;
      r = 0;
      g = 0;
      b = 0;
      if (s.rgb_on) begin
        if (sv == 0) begin
          // gray: all channels at full drive before brightness scaling
          r = DRIVE_MAX;
          g = DRIVE_MAX;
          b = DRIVE_MAX;
        end else begin
          sec  = sector_t'(hue / SECTOR_DEG);
          pos  = (hue - (hue / SECTOR_DEG) * SECTOR_DEG) * 6;
          lo   = (DRIVE_MAX * (FULL_SCALE - sv)) / FULL_SCALE;
          fall = (DRIVE_MAX * (FULL_SCALE - (sv * pos) / HUE_TURN)) / FULL_SCALE;
          rise = (DRIVE_MAX * (FULL_SCALE - (sv * (HUE_TURN - pos)) / HUE_TURN)) / FULL_SCALE;
          case (sec)
            SEC_RED_YEL: begin r = DRIVE_MAX; g = rise;      b = lo;        end
            SEC_YEL_GRN: begin r = fall;      g = DRIVE_MAX; b = lo;        end
            SEC_GRN_CYN: begin r = lo;        g = DRIVE_MAX; b = rise;      end
            SEC_CYN_BLU: begin r = lo;        g = fall;      b = DRIVE_MAX; end
            SEC_BLU_MAG: begin r = rise;      g = lo;        b = DRIVE_MAX; end
            default:     begin r = DRIVE_MAX; g = lo;        b = fall;      end
          endcase
        end
        r = (r * lvl) / FULL_SCALE;
        g = (g * lvl) / FULL_SCALE;
        b = (b * lvl) / FULL_SCALE;
      end
      o.red   = 8'(r);
      o.green = 8'(g);
      o.blue  = 8'(b);
      o.white = s.white_enable ? 8'(wb) : 8'd0;
      return o;
    endfunction

    function void note_setting(logic [IN_TDATA_W-1:0] d);
      hlcr_in_t s;
      s.rgb_on       = d[0];
      s.hue_deg      = d[9:1];
      s.sat          = d[17:10];
      s.bright       = d[25:18];
      s.white_enable = d[26];
      s.white_bright = d[34:27];
      pending_rgbw.push_back(render_rgbw(s));
      settings_seen++;
    endfunction

    function void check_drive(logic [OUT_TDATA_W-1:0] d);
      hlcr_out_t got, want;
      got = d;
      if (pending_rgbw.size() == 0) begin
        $error("drive value %h with no request outstanding", d);
        mismatches++;
        return;
      end
      want = pending_rgbw.pop_front();
      drives_checked++;
      if (got.red !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
        mismatches++;
      end
      if (got.white !== want.white) begin
        $error("white: expected %0d, actual %0d", want.white, got.white);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned send_idle = 0;
  int unsigned stall_pct = 0;
  rgbw_board   board = new();

  hsv_led_color_render dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      board.note_setting(in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      board.check_drive(out_tdata);
    end
  end

  function automatic hlcr_in_t lamp(int on, int hue, int sat, int bright, int we, int wb);
    hlcr_in_t s;
    s.rgb_on       = 1'(on);
    s.hue_deg      = 9'(hue);
    s.sat          = 8'(sat);
    s.bright       = 8'(bright);
    s.white_enable = 1'(we);
    s.white_bright = 8'(wb);
    return s;
  endfunction

  // Favor the clamp edges of the 0..254 scale, else uniform over the full byte.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd254;
      2: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic hlcr_in_t random_setting();
    hlcr_in_t s;
    s.rgb_on = ($urandom_range(7) != 0);
    // one in four lands on or just below a sector boundary
    if ($urandom_range(3) == 0) begin
      s.hue_deg = 9'(60 * $urandom_range(8)) - 9'($urandom_range(1));
    end else begin
      s.hue_deg = 9'($urandom_range(511));
    end
    s.sat          = pick_level();
    s.bright       = pick_level();
    s.white_enable = 1'($urandom_range(1));
    s.white_bright = pick_level();
    return s;
  endfunction

  task automatic send_setting(input hlcr_in_t s);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, s.white_bright, s.white_enable, s.bright, s.sat, s.hue_deg, s.rgb_on};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every outstanding request has come back, then settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_rgbw.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    hlcr_in_t directed[$];
    directed = '{
      lamp(0, 123, 200, 254, 1, 100),
      lamp(1,   0,   0, 254, 0, 254),
      lamp(1,   0, 254, 254, 1, 254),
      lamp(1,  59, 254, 254, 1, 255),
      lamp(1,  60, 254, 254, 0,   0),
      lamp(1, 120, 254, 254, 1,  17),
      lamp(1, 180, 254, 254, 1, 200),
      lamp(1, 240, 254, 254, 0, 255),
      lamp(1, 300, 254, 254, 1,   0),
      lamp(1, 359, 254, 254, 1,   1),
      lamp(1, 360, 200, 200, 1, 128),
      lamp(1, 511, 255, 255, 1, 255),
      lamp(1,  30, 128,   0, 1,  64),
      lamp(1,  90, 255, 255, 0, 127),
      lamp(1, 210,   1,   1, 1, 253),
      lamp(1, 270, 127, 128, 1,  85),
      lamp(0, 511, 255, 255, 1,   0),
      lamp(1, 330, 254, 255, 1,   1),
      lamp(1,   0,   0,   0, 0, 255),
      lamp(1, 450, 100, 254, 1, 254)
    };
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_setting(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  stall_pct <= 0;  end
        1: begin send_idle = 84; stall_pct <= 0;  end
        2: begin send_idle = 0;  stall_pct <= 84; end
        default: begin send_idle = 34; stall_pct <= 34; end
      endcase
      repeat (375) send_setting(random_setting());
      drain();
    end

    $display("Covered %0d lamp settings (%0d directed) under four sender/receiver idle mixes;",
             board.settings_seen, directed.size());
    $display("%0d RGBW drive values checked field by field.", board.drives_checked);
    if (board.mismatches == 0 && board.pending_rgbw.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ hsv_led_color_render.f @@
+incdir+design
design/hlcr_pkg.sv
design/hlcr_front.sv
design/hlcr_chroma.sv
design/hlcr_scale.sv
design/hsv_led_color_render.sv
tb/hsv_led_color_render_test.sv
